@@ design/cdtm_pkg.sv @@
// shared types and constants for the cursor dirty tile marker
// no dependencies; imported by every module of the block
package cdtm_pkg;

  // field widths
  localparam int CoordBits = 16;
  localparam int TileIdxW  = 16;
  localparam int PtrW      = 7;
  localparam int TsW       = 8;
  localparam int PageW     = 13;
  localparam int TprW      = 9;
  localparam int CfgIdxW   = 3;
  localparam int CfgDataW  = 13;
  localparam int PixW      = CoordBits + 1;

  // result limit per item
  localparam int MaxResults = 50;
  localparam int CntW       = 6;

  // clamps
  localparam logic [TsW-1:0]  MinTile = TsW'(16);
  localparam logic [PtrW-1:0] MaxPtr  = PtrW'(64);

  // register indexes
  localparam logic [CfgIdxW-1:0] CFG_POINTER_WIDTH  = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_POINTER_HEIGHT = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_TILE_SIZE      = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_PAGE_WIDTH     = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_PAGE_HEIGHT    = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_TILES_PER_ROW  = 3'd5;
  localparam logic [CfgIdxW-1:0] CFG_HARD_CURSOR    = 3'd6;

  // register reset values
  localparam logic [PtrW-1:0]  RstPointerWidth  = PtrW'(16);
  localparam logic [PtrW-1:0]  RstPointerHeight = PtrW'(16);
  localparam logic [TsW-1:0]   RstTileSize      = TsW'(32);
  localparam logic [PageW-1:0] RstPageWidth     = PageW'(1024);
  localparam logic [PageW-1:0] RstPageHeight    = PageW'(768);
  localparam logic [TprW-1:0]  RstTilesPerRow   = TprW'(32);

  // controller to datapath
  typedef struct packed {
    logic load_in;
    logic start_rect;
    logic rect_new;
    logic init;
    logic next_row;
    logic push;
    logic flush;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic changed;
    logic hard_cursor;
    logic div_done;
    logic row_ok;
    logic col_ok;
    logic rect_new;
    logic pend_v;
    logic out_free;
    logic cnt_last;
  } sts_t;

endpackage

@@ design/cdtm_div.sv @@
// two-lane restoring divider, one quotient bit per cycle in each lane
// depends on cdtm_pkg
module cdtm_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [cdtm_pkg::CoordBits-1:0] dvd_x_i,
  input  logic [cdtm_pkg::CoordBits-1:0] dvd_y_i,
  input  logic [cdtm_pkg::TsW-1:0]       dvs_i,
  output logic                          done_o,
  output logic [cdtm_pkg::CoordBits-1:0] quo_x_o,
  output logic [cdtm_pkg::CoordBits-1:0] quo_y_o,
  output logic [cdtm_pkg::TsW-1:0]       rem_x_o,
  output logic [cdtm_pkg::TsW-1:0]       rem_y_o
);
  import cdtm_pkg::*;

  localparam int StepW = $clog2(CoordBits);

  logic                 busy_q, done_q;
  logic [StepW-1:0]     step_q;
  logic [CoordBits-1:0] dvd_x_q, dvd_y_q;
  logic [TsW-1:0]       rem_x_q, rem_y_q, dvs_q;
  logic [TsW:0]         trial_x, trial_y, diff_x, diff_y;
  logic                 ge_x, ge_y;

  assign trial_x = {rem_x_q, dvd_x_q[CoordBits-1]};
  assign trial_y = {rem_y_q, dvd_y_q[CoordBits-1]};
  assign ge_x    = trial_x >= {1'b0, dvs_q};
  assign ge_y    = trial_y >= {1'b0, dvs_q};
  assign diff_x  = trial_x - {1'b0, dvs_q};
  assign diff_y  = trial_y - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + StepW'(1);
        if (step_q == StepW'(CoordBits - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_x_q <= dvd_x_i;
      dvd_y_q <= dvd_y_i;
      rem_x_q <= '0;
      rem_y_q <= '0;
      dvs_q   <= dvs_i;
    end else if (busy_q) begin
      dvd_x_q <= {dvd_x_q[CoordBits-2:0], ge_x};
      dvd_y_q <= {dvd_y_q[CoordBits-2:0], ge_y};
      rem_x_q <= ge_x ? diff_x[TsW-1:0] : trial_x[TsW-1:0];
      rem_y_q <= ge_y ? diff_y[TsW-1:0] : trial_y[TsW-1:0];
    end
  end

  assign done_o  = done_q;
  assign quo_x_o = dvd_x_q;
  assign quo_y_o = dvd_y_q;
  assign rem_x_o = rem_x_q;
  assign rem_y_o = rem_y_q;

endmodule

@@ design/cdtm_dp.sv @@
// datapath: config registers, pointer positions, tile walk, pending and output registers
// depends on cdtm_pkg and cdtm_div
module cdtm_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  input  logic [cdtm_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [cdtm_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic [cdtm_pkg::CoordBits-1:0] mouse_x_i,
  input  logic [cdtm_pkg::CoordBits-1:0] mouse_y_i,
  input  cdtm_pkg::cmd_t                 cmd_i,
  output cdtm_pkg::sts_t                 sts_o,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output logic [cdtm_pkg::TileIdxW-1:0]  tile_index_o,
  output logic                          tile_valid_o,
  output logic                          last_o
);
  import cdtm_pkg::*;

  localparam int ProdW = CoordBits + TprW;

  // configuration
  logic [PtrW-1:0]  ptr_w_q, ptr_h_q;
  logic [TsW-1:0]   tile_size_q;
  logic [PageW-1:0] page_w_q, page_h_q;
  logic [TprW-1:0]  tpr_q;
  logic             hard_q;

  // positions and walk state
  logic [CoordBits-1:0] old_x_q, old_y_q, new_x_q, new_y_q;
  logic                 rect_q;
  logic [PixW-1:0]      py_q, px_q, px0_q;
  logic [TileIdxW-1:0]  col_q, col0_q, row_base_q;
  logic [TileIdxW-1:0]  pend_idx_q;
  logic                 pend_v_q;
  logic [CntW-1:0]      cnt_q;

  // output register
  logic                 out_valid_q, tile_valid_q, last_q;
  logic [TileIdxW-1:0]  tile_index_q;

  logic [TsW-1:0]       ts_eff;
  logic [PtrW-1:0]      w_eff, h_eff;
  logic [CoordBits-1:0] cur_x, cur_y, div_x, div_y;
  logic [PixW-1:0]      x_end, y_end;
  logic                 div_done;
  logic [CoordBits-1:0] quo_x, quo_y;
  logic [TsW-1:0]       rem_x, rem_y;
  logic [ProdW-1:0]     prod;
  logic                 out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_w_q     <= RstPointerWidth;
      ptr_h_q     <= RstPointerHeight;
      tile_size_q <= RstTileSize;
      page_w_q    <= RstPageWidth;
      page_h_q    <= RstPageHeight;
      tpr_q       <= RstTilesPerRow;
      hard_q      <= 1'b0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_POINTER_WIDTH:  ptr_w_q     <= cfg_data_i[PtrW-1:0];
        CFG_POINTER_HEIGHT: ptr_h_q     <= cfg_data_i[PtrW-1:0];
        CFG_TILE_SIZE:      tile_size_q <= cfg_data_i[TsW-1:0];
        CFG_PAGE_WIDTH:     page_w_q    <= cfg_data_i[PageW-1:0];
        CFG_PAGE_HEIGHT:    page_h_q    <= cfg_data_i[PageW-1:0];
        CFG_TILES_PER_ROW:  tpr_q       <= cfg_data_i[TprW-1:0];
        CFG_HARD_CURSOR:    hard_q      <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign ts_eff = (tile_size_q < MinTile) ? MinTile : tile_size_q;
  assign w_eff  = (ptr_w_q > MaxPtr) ? MaxPtr : ptr_w_q;
  assign h_eff  = (ptr_h_q > MaxPtr) ? MaxPtr : ptr_h_q;

  assign cur_x = rect_q ? new_x_q : old_x_q;
  assign cur_y = rect_q ? new_y_q : old_y_q;
  assign div_x = cmd_i.rect_new ? new_x_q : old_x_q;
  assign div_y = cmd_i.rect_new ? new_y_q : old_y_q;

  assign x_end = {1'b0, cur_x} + PixW'(w_eff);
  assign y_end = {1'b0, cur_y} + PixW'(h_eff);

  cdtm_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.start_rect),
    .dvd_x_i (div_x),
    .dvd_y_i (div_y),
    .dvs_i   (ts_eff),
    .done_o  (div_done),
    .quo_x_o (quo_x),
    .quo_y_o (quo_y),
    .rem_x_o (rem_x),
    .rem_y_o (rem_y)
  );

  assign prod = quo_y * tpr_q;

  // control state of the walk
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      old_x_q  <= '0;
      old_y_q  <= '0;
      rect_q   <= 1'b0;
      pend_v_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      if (cmd_i.start_rect) rect_q <= cmd_i.rect_new;
      if (cmd_i.load_in) cnt_q <= '0;
      if (cmd_i.push) begin
        pend_v_q <= 1'b1;
        cnt_q    <= cnt_q + CntW'(1);
      end
      if (cmd_i.flush) begin
        pend_v_q <= 1'b0;
        old_x_q  <= new_x_q;
        old_y_q  <= new_y_q;
      end
    end
  end

  // walk payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      new_x_q <= mouse_x_i;
      new_y_q <= mouse_y_i;
    end
    if (cmd_i.init) begin
      py_q       <= {1'b0, cur_y - CoordBits'(rem_y)};
      px_q       <= {1'b0, cur_x - CoordBits'(rem_x)};
      px0_q      <= {1'b0, cur_x - CoordBits'(rem_x)};
      col_q      <= quo_x;
      col0_q     <= quo_x;
      row_base_q <= prod[TileIdxW-1:0];
    end
    if (cmd_i.next_row) begin
      py_q       <= py_q + PixW'(ts_eff);
      px_q       <= px0_q;
      col_q      <= col0_q;
      row_base_q <= row_base_q + TileIdxW'(tpr_q);
    end
    if (cmd_i.push) begin
      px_q       <= px_q + PixW'(ts_eff);
      col_q      <= col_q + TileIdxW'(1);
      pend_idx_q <= row_base_q + col_q;
    end
  end

  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      if ((cmd_i.push && pend_v_q) || cmd_i.flush) out_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push && pend_v_q) begin
      tile_index_q <= pend_idx_q;
      tile_valid_q <= 1'b1;
      last_q       <= 1'b0;
    end
    if (cmd_i.flush) begin
      tile_index_q <= pend_v_q ? pend_idx_q : '0;
      tile_valid_q <= pend_v_q;
      last_q       <= 1'b1;
    end
  end

  assign sts_o.changed     = (mouse_x_i != old_x_q) || (mouse_y_i != old_y_q);
  assign sts_o.hard_cursor = hard_q;
  assign sts_o.div_done    = div_done;
  assign sts_o.row_ok      = (py_q < y_end) && (py_q < PixW'(page_h_q));
  assign sts_o.col_ok      = (px_q < x_end) && (px_q < PixW'(page_w_q));
  assign sts_o.rect_new    = rect_q;
  assign sts_o.pend_v      = pend_v_q;
  assign sts_o.out_free    = out_free;
  assign sts_o.cnt_last    = cnt_q == CntW'(MaxResults - 1);

  assign out_valid_o  = out_valid_q;
  assign tile_index_o = tile_index_q;
  assign tile_valid_o = tile_valid_q;
  assign last_o       = last_q;

endmodule

@@ design/cdtm_ctrl.sv @@
// controller: sequences division, tile walk over both rectangles and the final flush
// depends on cdtm_pkg
module cdtm_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  cdtm_pkg::sts_t sts_i,
  output cdtm_pkg::cmd_t cmd_o
);
  import cdtm_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_DIV   = 3'd1;
  localparam logic [2:0] ST_INIT  = 3'd2;
  localparam logic [2:0] ST_WALK  = 3'd3;
  localparam logic [2:0] ST_FLUSH = 3'd4;

  logic [2:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else         state_q <= state_d;
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          if (sts_i.changed && !sts_i.hard_cursor) begin
            cmd_o.start_rect = 1'b1;
            cmd_o.rect_new   = 1'b0;
            state_d          = ST_DIV;
          end else begin
            state_d = ST_FLUSH;
          end
        end
      end
      ST_DIV: begin
        if (sts_i.div_done) state_d = ST_INIT;
      end
      ST_INIT: begin
        cmd_o.init = 1'b1;
        state_d    = ST_WALK;
      end
      ST_WALK: begin
        if (!sts_i.row_ok) begin
          if (!sts_i.rect_new) begin
            cmd_o.start_rect = 1'b1;
            cmd_o.rect_new   = 1'b1;
            state_d          = ST_DIV;
          end else begin
            state_d = ST_FLUSH;
          end
        end else if (!sts_i.col_ok) begin
          cmd_o.next_row = 1'b1;
        end else if (!sts_i.pend_v || sts_i.out_free) begin
          cmd_o.push = 1'b1;
          if (sts_i.cnt_last) state_d = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (sts_i.out_free) begin
          cmd_o.flush = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

@@ design/cursor_dirty_tile_marker.sv @@
// an unchanged position or a hard cursor gives its single result from the flush that follows accept
// otherwise each rectangle, old then new, is divided, set up and walked tile by tile and row by row
// until it closes; a flush ends the item
// throughput: one item at a time; 16-step divider, then one tile per cycle unless output stalls
// reset: registers take their defaults, the stored pointer position clears to zero
// depends on cdtm_pkg, cdtm_ctrl, cdtm_dp and cdtm_div
module cursor_dirty_tile_marker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // input items: pointer position
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [cdtm_pkg::CoordBits-1:0] mouse_x_i,
  input  logic [cdtm_pkg::CoordBits-1:0] mouse_y_i,
  // result items: dirty tiles
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [cdtm_pkg::TileIdxW-1:0]  tile_index_o,
  output logic                          tile_valid_o,
  output logic                          last_o,
  // configuration writes
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [cdtm_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [cdtm_pkg::CfgDataW-1:0]  cfg_data_i
);
  import cdtm_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // register writes never stall
  assign cfg_ready_o = 1'b1;

  // sequencer: idle, divide, set up the walk, walk tiles, flush the last item
  cdtm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // datapath: a tile is held in a pending register so the final one can carry last
  cdtm_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .mouse_x_i    (mouse_x_i),
    .mouse_y_i    (mouse_y_i),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_ready_i  (out_ready_i),
    .out_valid_o  (out_valid_o),
    .tile_index_o (tile_index_o),
    .tile_valid_o (tile_valid_o),
    .last_o       (last_o)
  );

`ifndef SYNTHESIS
  // an empty result is always the final one of its item
  a_empty_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !tile_valid_o) |-> last_o)
    else $error("empty result without last");

  // nothing is held back once the block is idle
  a_idle_no_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !sts.pend_v)
    else $error("pending tile left while idle");

  // an accepted item leaves the block busy in the cycle after it is taken
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("item accepted back to back");

  // a held tile only moves on when the output register can take it
  a_push_has_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.push |-> (!sts.pend_v || sts.out_free))
    else $error("tile pushed into a full output register");
`endif

endmodule
